// ===== hw/rtl/grid_line_of_sight_check_defines.svh =====
// Assertion macros shared by the RTL of the grid line-of-sight checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef GRID_LINE_OF_SIGHT_CHECK_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLOS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/glos_pkg.sv =====
// Package for the grid line-of-sight checker: grid sizes, field widths,
// register map and the structs passed between the top level and the walker.
// No dependencies.
package glos_pkg;

  localparam int GRID_W    = 64;
  localparam int GRID_H    = 64;
  localparam int MAP_DEPTH = GRID_W * GRID_H;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  localparam int COORD_W = 6;
  localparam int RANGE_W = 7;
  localparam int RW_W    = 7;
  localparam int TIDX_W  = 12;
  localparam int CNT_W   = 7;
  localparam int E_W     = 17;

  // Linear probe address: x + y * row_width with x in -1..64, y in 0..64,
  // carried in two's complement and wide enough for the map depth as well.
  localparam int PADDR_W = (MAP_AW + 1 > 15) ? MAP_AW + 1 : 15;

  localparam logic [RW_W-1:0] RW_RESET = 7'd64;

  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_SEL_LSB = 2;
  localparam logic [APB_AW-REG_SEL_LSB-1:0] REG_ROW_WIDTH = '0;

  typedef struct packed {
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [COORD_W-1:0] to_x;
    logic [COORD_W-1:0] to_y;
    logic [RANGE_W-1:0] sight_range;
    logic [RW_W-1:0]    row_width;
  } glos_query_t;

  typedef struct packed {
    logic active;
    logic fin;
    logic visible;
  } glos_walk_res_t;

endpackage

// ===== hw/rtl/glos_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/glos_walk.sv =====
// Line-of-sight walker: sequencer plus a shared step unit (address and
// corner-error adders) that probes the tile map one cell per read.
// Depends on glos_pkg; reads the map through an external registered-read port.
module glos_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  glos_pkg::glos_query_t         query,
  output logic [glos_pkg::MAP_AW-1:0]   rd_addr,
  input  logic                          rd_data,
  output glos_pkg::glos_walk_res_t      res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_COL    = 4'd3;
  localparam logic [3:0] S_COLCHK = 4'd4;
  localparam logic [3:0] S_DIAG0  = 4'd5;
  localparam logic [3:0] S_DIAG1  = 4'd6;
  localparam logic [3:0] S_DIAG2  = 4'd7;
  localparam logic [3:0] S_LOOP   = 4'd8;
  localparam logic [3:0] S_LCHK   = 4'd9;
  localparam logic [3:0] S_LS1    = 4'd10;
  localparam logic [3:0] S_LS2    = 4'd11;

  localparam int CW  = glos_pkg::COORD_W;
  localparam int PW  = glos_pkg::PADDR_W;
  localparam int EW  = glos_pkg::E_W;
  localparam int NW  = glos_pkg::CNT_W;
  localparam int MW  = glos_pkg::COORD_W + glos_pkg::RW_W;
  localparam logic [PW-1:0] MAP_DEPTH_P = PW'(glos_pkg::MAP_DEPTH);

  logic [3:0] st_r, st_nxt;

  logic [CW-1:0]                  x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [glos_pkg::RANGE_W-1:0]   range_r, range_nxt;
  logic [glos_pkg::RW_W-1:0]      rw_r, rw_nxt;
  logic [CW-1:0]                  adx_r, adx_nxt, dy_r, dy_nxt;
  logic                           neg_r, neg_nxt;
  logic [NW-1:0]                  dist_r, dist_nxt;
  logic [PW-1:0]                  addr_r, addr_nxt;
  logic [EW-1:0]                  e_r, e_nxt;
  logic [NW-1:0]                  u_r, u_nxt, v_r, v_nxt, n_r, n_nxt;
  logic                           ok_r, ok_nxt;

  // set-up arithmetic
  logic          neg_c;
  logic [CW-1:0] adx_c, dy_c;
  logic [MW-1:0] mul_c;

  // shared step unit
  logic          step_x;
  logic [PW-1:0] rw_ext, xstep, addr_step;
  logic [EW-1:0] e_step;
  logic          e_pos, e_zero;

  // probe address
  logic [PW-1:0] probe_c;
  logic          hit;
  logic          do_step, do_cnt, fin, vis;

  assign neg_c = x2_r < x1_r;
  assign adx_c = neg_c ? (x1_r - x2_r) : (x2_r - x1_r);
  assign dy_c  = y2_r - y1_r;
  assign mul_c = MW'(y1_r) * MW'(rw_r);

  assign rw_ext = PW'(rw_r);
  assign xstep  = neg_r ? {PW{1'b1}} : PW'(1);
  assign e_zero = (e_r == '0);
  assign e_pos  = !e_r[EW-1] && !e_zero;

  always_comb begin
    unique case (st_r)
      S_INIT, S_DIAG2: step_x = !(dy_r > adx_r);
      S_LCHK, S_LS2:   step_x = e_pos;
      default:         step_x = 1'b0;
    endcase
  end

  // Column step: error drops by twice dy; row step: error rises by twice |dx|.
  assign e_step    = step_x ? (e_r - EW'({dy_r, 1'b0})) : (e_r + EW'({adx_r, 1'b0}));
  assign addr_step = addr_r + (step_x ? xstep : rw_ext);

  always_comb begin
    unique case (st_r)
      S_DIAG0, S_LCHK: probe_c = addr_r + rw_ext;
      S_DIAG1, S_LS1:  probe_c = addr_r + xstep;
      default:         probe_c = addr_r;
    endcase
  end

  assign ok_nxt  = !probe_c[PW-1] && (probe_c < MAP_DEPTH_P);
  assign rd_addr = probe_c[glos_pkg::MAP_AW-1:0];
  assign hit     = rd_data & ok_r;

  always_comb begin
    st_nxt    = st_r;
    x1_nxt    = x1_r;
    y1_nxt    = y1_r;
    x2_nxt    = x2_r;
    y2_nxt    = y2_r;
    range_nxt = range_r;
    rw_nxt    = rw_r;
    adx_nxt   = adx_r;
    dy_nxt    = dy_r;
    neg_nxt   = neg_r;
    dist_nxt  = dist_r;
    addr_nxt  = addr_r;
    e_nxt     = e_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    n_nxt     = n_r;
    do_step   = 1'b0;
    do_cnt    = 1'b0;
    fin       = 1'b0;
    vis       = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (go) begin
          // order the end points so that the first has the smaller row
          if (query.from_y > query.to_y) begin
            x1_nxt = query.to_x;
            y1_nxt = query.to_y;
            x2_nxt = query.from_x;
            y2_nxt = query.from_y;
          end else begin
            x1_nxt = query.from_x;
            y1_nxt = query.from_y;
            x2_nxt = query.to_x;
            y2_nxt = query.to_y;
          end
          range_nxt = query.sight_range;
          rw_nxt    = query.row_width;
          st_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        adx_nxt  = adx_c;
        dy_nxt   = dy_c;
        neg_nxt  = neg_c;
        dist_nxt = NW'(adx_c) + NW'(dy_c);
        addr_nxt = PW'(mul_c) + PW'(x1_r);
        e_nxt    = EW'(adx_c) - EW'(dy_c);
        u_nxt    = '0;
        v_nxt    = '0;
        n_nxt    = '0;
        st_nxt   = S_INIT;
      end
      S_INIT: begin
        if (dist_r > range_r) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else if (adx_r == '0 && dy_r == '0) begin
          fin    = 1'b1;
          vis    = 1'b1;
          st_nxt = S_IDLE;
        end else if (adx_r == '0) begin
          do_step = 1'b1;
          st_nxt  = S_COL;
        end else if (dy_r == adx_r) begin
          st_nxt = S_DIAG0;
        end else begin
          do_step = 1'b1;
          st_nxt  = S_LOOP;
        end
      end
      S_COL: begin
        if (v_r >= NW'(dy_r)) begin
          fin    = 1'b1;
          vis    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_COLCHK;
        end
      end
      S_COLCHK: begin
        if (hit) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          do_step = 1'b1;
          st_nxt  = S_COL;
        end
      end
      S_DIAG0: begin
        st_nxt = S_DIAG1;
      end
      S_DIAG1: begin
        if (hit) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_DIAG2;
        end
      end
      S_DIAG2: begin
        if (hit) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          do_step = 1'b1;
          st_nxt  = S_LOOP;
        end
      end
      S_LOOP: begin
        if (n_r == dist_r || (u_r == NW'(adx_r) && v_r == NW'(dy_r))) begin
          fin    = 1'b1;
          vis    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (hit) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else if (e_zero) begin
          // line runs through the corner: test both side cells
          st_nxt = S_LS1;
        end else begin
          do_step = 1'b1;
          do_cnt  = 1'b1;
          st_nxt  = S_LOOP;
        end
      end
      S_LS1: begin
        if (hit) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_LS2;
        end
      end
      S_LS2: begin
        if (hit) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          do_step = 1'b1;
          do_cnt  = 1'b1;
          st_nxt  = S_LOOP;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (do_step) begin
      addr_nxt = addr_step;
      e_nxt    = e_step;
      u_nxt    = u_r + NW'(step_x);
      v_nxt    = v_r + NW'(!step_x);
    end
    if (do_cnt) begin
      n_nxt = n_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    x2_r    <= x2_nxt;
    y2_r    <= y2_nxt;
    range_r <= range_nxt;
    rw_r    <= rw_nxt;
    adx_r   <= adx_nxt;
    dy_r    <= dy_nxt;
    neg_r   <= neg_nxt;
    dist_r  <= dist_nxt;
    addr_r  <= addr_nxt;
    e_r     <= e_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    n_r     <= n_nxt;
    ok_r    <= ok_nxt;
  end

  assign res.active  = (st_r != S_IDLE);
  assign res.fin     = fin;
  assign res.visible = vis;

endmodule

// ===== hw/rtl/grid_line_of_sight_check.sv =====
// Top level of the grid line-of-sight checker: command port, APB register,
// tile map RAM with its clearing pass, result register.
// Depends on glos_pkg, glos_ram, glos_walk and grid_line_of_sight_check_defines.svh.
//
//   channel   handshake                    payload
//   input     start && !busy               in_kind .. in_tile_blocked
//   result    out_valid (one cycle)        out_visible
//   config    psel, penable, pwrite, pready  paddr, pwdata / prdata
//
// A write transaction's result shows in the next cycle.
// A query walks the line cell by cell and also probes the two side cells on an exact
// diagonal and at each corner the line runs through: every cell costs one read of the
// single map read port and a check of its data.
// After reset busy stays high while the map is cleared.
// The result is shown for one cycle and cannot be held off.
`include "grid_line_of_sight_check_defines.svh"

module grid_line_of_sight_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic [glos_pkg::COORD_W-1:0]     in_from_x,
  input  logic [glos_pkg::COORD_W-1:0]     in_from_y,
  input  logic [glos_pkg::COORD_W-1:0]     in_to_x,
  input  logic [glos_pkg::COORD_W-1:0]     in_to_y,
  input  logic [glos_pkg::RANGE_W-1:0]     in_sight_range,
  input  logic [glos_pkg::TIDX_W-1:0]      in_tile_index,
  input  logic                             in_tile_blocked,
  output logic                             out_valid,
  output logic                             out_visible,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [glos_pkg::APB_AW-1:0]      paddr,
  input  logic [glos_pkg::APB_DW-1:0]      pwdata,
  output logic [glos_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int AW = glos_pkg::MAP_AW;
  localparam logic [AW-1:0] CLR_LAST = AW'(glos_pkg::MAP_DEPTH - 1);

  logic [glos_pkg::RW_W-1:0] row_width_r, row_width_nxt;
  logic                      clr_active_r, clr_active_nxt;
  logic [AW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_visible_r, out_visible_nxt;

  logic                      in_acc, wr_acc, reg_sel, cfg_we;
  logic                      ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  glos_pkg::glos_query_t     query;
  glos_pkg::glos_walk_res_t  wk_res;

  assign busy   = clr_active_r | wk_res.active;
  assign in_acc = start & !busy;
  assign wr_acc = in_acc & in_kind;

  // APB register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[glos_pkg::APB_AW-1:glos_pkg::REG_SEL_LSB] == glos_pkg::REG_ROW_WIDTH);
  assign cfg_we  = psel & penable & pwrite & pready & reg_sel;
  assign prdata  = reg_sel ? glos_pkg::APB_DW'(row_width_r) : '0;
  assign row_width_nxt = cfg_we ? pwdata[glos_pkg::RW_W-1:0] : row_width_r;

  // Clearing pass, then tile writes; writes off the store are dropped.
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      ram_we      = 1'b1;
      ram_waddr   = clr_cnt_r;
      ram_wdata   = 1'b0;
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_nxt = 1'b0;
      end
    end else begin
      ram_we    = wr_acc && (32'(in_tile_index) < 32'(glos_pkg::MAP_DEPTH));
      ram_waddr = AW'(in_tile_index);
      ram_wdata = in_tile_blocked;
    end
  end

  assign query.from_x      = in_from_x;
  assign query.from_y      = in_from_y;
  assign query.to_x        = in_to_x;
  assign query.to_y        = in_to_y;
  assign query.sight_range = in_sight_range;
  assign query.row_width   = row_width_r;

  glos_ram #(
    .WIDTH (1),
    .DEPTH (glos_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  glos_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (in_acc & !in_kind),
    .query   (query),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .res     (wk_res)
  );

  assign out_valid_nxt   = wr_acc | wk_res.fin;
  assign out_visible_nxt = wk_res.fin & wk_res.visible;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= glos_pkg::RW_RESET;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      row_width_r  <= row_width_nxt;
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= out_visible_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  `GLOS_ASSERT_NEXT(a_res_follows, wk_res.fin || wr_acc, out_valid, "result strobe missing")
  `GLOS_ASSERT_NEXT(a_wr_not_visible, wr_acc, out_valid && !out_visible, "write result not zero")
  `GLOS_ASSERT_SAME(a_clr_busy, clr_active_r, busy, "transaction possible while clearing")
  `GLOS_ASSERT_SAME(a_fin_no_accept, wk_res.fin, !in_acc, "transaction taken while walking")

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for grid_line_of_sight_check: drives tile writes and sight queries,
// predicts each visible bit from a local copy of the tile map and row width.
// Depends on glos_pkg and the RTL of the block only.
module testbench;
  import glos_pkg::*;

  typedef enum logic {
    CMD_QUERY      = 1'b0,
    CMD_WRITE_TILE = 1'b1
  } cmd_kind_e;

  typedef struct {
    cmd_kind_e          kind;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [COORD_W-1:0] to_x;
    logic [COORD_W-1:0] to_y;
    logic [RANGE_W-1:0] sight_range;
    logic [TIDX_W-1:0]  tile_index;
    logic               tile_blocked;
  } sight_cmd_t;

  localparam int MAX_RANGE = 126;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [APB_AW-1:0] ROW_WIDTH_ADDR = {REG_ROW_WIDTH, {REG_SEL_LSB{1'b0}}};
  localparam logic [APB_AW-1:0] UNUSED_REG_ADDR = {1'b1, {REG_SEL_LSB{1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_kind = 1'b0;
  logic [COORD_W-1:0]   in_from_x = '0;
  logic [COORD_W-1:0]   in_from_y = '0;
  logic [COORD_W-1:0]   in_to_x = '0;
  logic [COORD_W-1:0]   in_to_y = '0;
  logic [RANGE_W-1:0]   in_sight_range = '0;
  logic [TIDX_W-1:0]    in_tile_index = '0;
  logic                 in_tile_blocked = 1'b0;
  logic                 out_valid;
  logic                 out_visible;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  bit                   blocking_tiles [MAP_DEPTH];
  logic [RW_W-1:0]      row_width_q = RW_RESET;
  bit                   expected_visible [$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   sender_idle_pct = 0;
  int                   win_x = 0;
  int                   win_y = 0;
  int                   win_s = 8;

  grid_line_of_sight_check i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_from_x       (in_from_x),
    .in_from_y       (in_from_y),
    .in_to_x         (in_to_x),
    .in_to_y         (in_to_y),
    .in_sight_range  (in_sight_range),
    .in_tile_index   (in_tile_index),
    .in_tile_blocked (in_tile_blocked),
    .out_valid       (out_valid),
    .out_visible     (out_visible),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Linear addressing is not folded into the row; anything off the map reads clear.
  function automatic bit tile_is_blocked(input int x, input int y);
    int addr;
    addr = x + y * int'(row_width_q);
    if (addr < 0 || addr >= MAP_DEPTH) return 1'b0;
    return blocking_tiles[addr];
  endfunction

  function automatic bit predict_visible(input sight_cmd_t c);
    int x1, y1, x2, y2, swap_v;
    int dx, dy, adx, walk_len, x, y, xdir, num, den, n;
    x1 = int'(c.from_x);
    y1 = int'(c.from_y);
    x2 = int'(c.to_x);
    y2 = int'(c.to_y);
    if (y1 > y2) begin
      swap_v = x1; x1 = x2; x2 = swap_v;
      swap_v = y1; y1 = y2; y2 = swap_v;
    end
    dx = x2 - x1;
    dy = y2 - y1;
    adx = iabs(dx);
    walk_len = adx + dy;
    if (walk_len > int'(c.sight_range)) return 1'b0;
    x = x1;
    y = y1;
    if (dx == 0) begin
      if (dy == 0) return 1'b1;
      // endpoints themselves are never tested on a vertical line
      for (y = y1 + 1; y < y2; y++)
        if (tile_is_blocked(x, y)) return 1'b0;
      return 1'b1;
    end
    xdir = (dx > 0) ? 1 : -1;
    if (dy == adx) begin
      if (tile_is_blocked(x, y + 1) || tile_is_blocked(x + xdir, y)) return 1'b0;
    end
    if (dy > adx) y++;
    else x += xdir;
    for (n = 0; n < walk_len && !(x == x2 && y == y2); n++) begin
      num = 2 * (y - y1) + 1;
      den = 2 * (x - x1) + xdir;
      if (tile_is_blocked(x, y)) return 1'b0;
      // line runs exactly through the corner: either side cell blocks
      if (num * dx == dy * den) begin
        if (tile_is_blocked(x, y + 1) || tile_is_blocked(x + xdir, y)) return 1'b0;
      end
      if (num * adx > dy * iabs(den)) x += xdir;
      else y++;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin : check_results
    bit want;
    if (rst_n && out_valid) begin
      if (expected_visible.size() == 0) begin
        $display("%0t: result transaction with none expected, actual visible=%b",
                 $time, out_visible);
        mismatch_count++;
      end else begin
        want = expected_visible.pop_front();
        if (out_visible !== want) begin
          $display("%0t: visible mismatch, expected %b actual %b", $time, want, out_visible);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Leave start high on return so that a following command goes out back to back.
  task automatic send_cmd(input sight_cmd_t c);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start           <= 1'b1;
    in_kind         <= c.kind;
    in_from_x       <= c.from_x;
    in_from_y       <= c.from_y;
    in_to_x         <= c.to_x;
    in_to_y         <= c.to_y;
    in_sight_range  <= c.sight_range;
    in_tile_index   <= c.tile_index;
    in_tile_blocked <= c.tile_blocked;
    do @(posedge clk); while (busy);
    if (c.kind == CMD_WRITE_TILE) begin
      expected_visible.push_back(1'b0);
      if (int'(c.tile_index) < MAP_DEPTH) blocking_tiles[c.tile_index] = c.tile_blocked;
    end else begin
      expected_visible.push_back(predict_visible(c));
    end
  endtask

  // Hold off until every outstanding result has been seen and the block is free.
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_visible.size() != 0 || busy) @(posedge clk);
  endtask

  // Hold the bus idle after the access.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [RW_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(APB_DW - RW_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ROW_WIDTH_ADDR) row_width_q = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_row_width();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ROW_WIDTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(row_width_q)) begin
      $display("%0t: row_width read mismatch, expected %0d actual %0d",
               $time, row_width_q, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic sight_cmd_t random_fields();
    sight_cmd_t c;
    c.kind         = CMD_QUERY;
    c.from_x       = COORD_W'($urandom);
    c.from_y       = COORD_W'($urandom);
    c.to_x         = COORD_W'($urandom);
    c.to_y         = COORD_W'($urandom);
    c.sight_range  = RANGE_W'($urandom_range(0, MAX_RANGE));
    c.tile_index   = TIDX_W'($urandom);
    c.tile_blocked = 1'($urandom);
    return c;
  endfunction

  function automatic sight_cmd_t query_cmd(input int fx, input int fy, input int tx,
                                           input int ty, input int rng);
    sight_cmd_t c;
    c = random_fields();
    c.from_x      = COORD_W'(fx);
    c.from_y      = COORD_W'(fy);
    c.to_x        = COORD_W'(tx);
    c.to_y        = COORD_W'(ty);
    c.sight_range = RANGE_W'(rng);
    return c;
  endfunction

  function automatic sight_cmd_t tile_cmd(input int x, input int y, input bit blk);
    sight_cmd_t c;
    c = random_fields();
    c.kind         = CMD_WRITE_TILE;
    c.tile_index   = TIDX_W'(x + y * int'(row_width_q));
    c.tile_blocked = blk;
    return c;
  endfunction

  // Most traffic stays inside a small window so that blocked tiles build up
  // densely enough for walks to hit them.
  function automatic sight_cmd_t random_cmd();
    sight_cmd_t c;
    int sel, addr, d;
    c = random_fields();
    sel = $urandom_range(99);
    if (sel < 35) begin
      c.kind = CMD_WRITE_TILE;
      addr = win_x + $urandom_range(0, win_s)
           + (win_y + $urandom_range(0, win_s)) * int'(row_width_q);
      if (addr >= MAP_DEPTH) addr = $urandom_range(0, MAP_DEPTH - 1);
      c.tile_index   = TIDX_W'(addr);
      c.tile_blocked = ($urandom_range(99) < 45);
    end else if (sel < 42) begin
      c.kind = CMD_WRITE_TILE;
    end else begin
      if (sel < 88) begin
        c.from_x = COORD_W'(win_x + $urandom_range(0, win_s));
        c.from_y = COORD_W'(win_y + $urandom_range(0, win_s));
        c.to_x   = COORD_W'(win_x + $urandom_range(0, win_s));
        c.to_y   = COORD_W'(win_y + $urandom_range(0, win_s));
      end
      d = iabs(int'(c.from_x) - int'(c.to_x)) + iabs(int'(c.from_y) - int'(c.to_y));
      d += $urandom_range(0, 3);
      if ($urandom_range(9) < 8) c.sight_range = RANGE_W'((d > MAX_RANGE) ? MAX_RANGE : d);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_register_access();
    wait_for_results();
    check_row_width();
    apb_write(UNUSED_REG_ADDR, RW_W'(5));
    check_row_width();
  endtask

  task automatic test_corner_cases();
    sender_idle_pct = 15;
    send_cmd(query_cmd(7, 7, 7, 7, 0));        // same point, zero range
    send_cmd(query_cmd(0, 0, 63, 63, 126));    // full span on a clear map
    send_cmd(query_cmd(0, 0, 63, 63, 125));    // one short of the range
    send_cmd(query_cmd(63, 0, 0, 63, 126));    // diagonal leftwards
    send_cmd(tile_cmd(5, 10, 1'b1));
    send_cmd(query_cmd(5, 3, 5, 20, 30));      // same column, blocked between
    send_cmd(query_cmd(5, 10, 5, 20, 30));     // blocked tile is an endpoint
    send_cmd(query_cmd(5, 20, 5, 3, 30));      // points given in reverse
    send_cmd(tile_cmd(20, 21, 1'b1));
    send_cmd(query_cmd(20, 20, 24, 24, 8));    // diagonal, cell above start blocked
    send_cmd(query_cmd(24, 24, 20, 20, 8));
    send_cmd(tile_cmd(31, 31, 1'b1));
    send_cmd(query_cmd(30, 30, 36, 32, 8));    // line through a corner
    send_cmd(query_cmd(40, 30, 46, 32, 8));
    send_cmd(tile_cmd(0, 0, 1'b1));
    send_cmd(query_cmd(0, 1, 1, 0, 2));        // diagonal, side cell at address zero
    send_cmd(tile_cmd(63, 63, 1'b1));
    send_cmd(query_cmd(62, 62, 63, 63, 2));
    send_cmd(query_cmd(10, 0, 40, 5, 126));    // shallow
    send_cmd(query_cmd(10, 0, 12, 60, 126));   // steep
    send_cmd(tile_cmd(63, 63, 1'b0));
    send_cmd(tile_cmd(0, 0, 1'b0));
    send_cmd(tile_cmd(5, 10, 1'b0));
    send_cmd(query_cmd(5, 3, 5, 20, 30));
  endtask

  task automatic test_random_walks(input logic [RW_W-1:0] width, input int idle_pct,
                                   input int n_items);
    int i;
    wait_for_results();
    apb_write(ROW_WIDTH_ADDR, width);
    check_row_width();
    sender_idle_pct = idle_pct;
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        win_s = $urandom_range(2, 15);
        win_x = $urandom_range(0, 63 - win_s);
        win_y = $urandom_range(0, 63 - win_s);
      end
      send_cmd(random_cmd());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_corner_cases();
    test_random_walks(RW_W'(64), 15, 200);
    test_random_walks(RW_W'(1), 15, 110);
    test_random_walks(RW_W'(37), 85, 160);
    test_random_walks(RW_W'(0), 85, 90);
    test_random_walks(RW_W'(127), 0, 170);
    test_random_walks(RW_W'(64), 0, 200);
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_visible.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/glos_pkg.sv
hw/rtl/glos_ram.sv
hw/rtl/glos_walk.sv
hw/rtl/grid_line_of_sight_check.sv
sim/testbench.sv
